### src/owss_pkg.sv
// Shared types, constants and the weight table of the weighted square-sum block.
package owss_pkg;

  localparam int VALUE_WIDTH   = 24;
  localparam int ORDER_WIDTH   = 5;
  localparam int POS_WIDTH     = 6;
  localparam int WEIGHT_WIDTH  = 11;
  localparam int SUM_WIDTH     = 63;
  localparam int SQ_WIDTH      = 2 * VALUE_WIDTH;
  localparam int PROD_WIDTH    = SQ_WIDTH + WEIGHT_WIDTH;
  localparam int NUM_ORDERS    = 10;
  localparam int MAX_RUNS      = 12;
  localparam int ORDER_IDX_W   = $clog2(NUM_ORDERS);
  localparam int ORDER_MIN     = -1;
  localparam int ORDER_MAX     = NUM_ORDERS - 1;
  localparam int QUEUE_DEPTH   = 2;
  localparam int OUT_DEPTH     = 6;

  // Run table: each run ends (exclusive) at the given element position.
  localparam logic [POS_WIDTH-1:0] RUN_END [NUM_ORDERS][MAX_RUNS] = '{
    '{6'd1,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd3,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd3,  6'd6,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd3,  6'd9,  6'd10, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd3,  6'd9,  6'd12, 6'd15, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd3,  6'd9,  6'd15, 6'd18, 6'd21, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd3,  6'd9,  6'd15, 6'd18, 6'd21, 6'd27, 6'd28, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd3,  6'd9,  6'd15, 6'd18, 6'd24, 6'd30, 6'd33, 6'd36, 6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd3,  6'd9,  6'd15, 6'd18, 6'd24, 6'd30, 6'd33, 6'd39, 6'd42, 6'd45, 6'd0,  6'd0},
    '{6'd3,  6'd9,  6'd15, 6'd18, 6'd24, 6'd30, 6'd36, 6'd42, 6'd45, 6'd48, 6'd54, 6'd55}
  };

  localparam logic [WEIGHT_WIDTH-1:0] RUN_WEIGHT [NUM_ORDERS][MAX_RUNS] = '{
    '{11'd1, 11'd0, 11'd0,  11'd0,  11'd0,  11'd0,   11'd0,   11'd0,   11'd0,   11'd0,
      11'd0, 11'd0},
    '{11'd1, 11'd0, 11'd0,  11'd0,  11'd0,  11'd0,   11'd0,   11'd0,   11'd0,   11'd0,
      11'd0, 11'd0},
    '{11'd1, 11'd2, 11'd0,  11'd0,  11'd0,  11'd0,   11'd0,   11'd0,   11'd0,   11'd0,
      11'd0, 11'd0},
    '{11'd1, 11'd3, 11'd6,  11'd0,  11'd0,  11'd0,   11'd0,   11'd0,   11'd0,   11'd0,
      11'd0, 11'd0},
    '{11'd1, 11'd4, 11'd6,  11'd12, 11'd0,  11'd0,   11'd0,   11'd0,   11'd0,   11'd0,
      11'd0, 11'd0},
    '{11'd1, 11'd5, 11'd10, 11'd20, 11'd30, 11'd0,   11'd0,   11'd0,   11'd0,   11'd0,
      11'd0, 11'd0},
    '{11'd1, 11'd6, 11'd15, 11'd30, 11'd20, 11'd60,  11'd90,  11'd0,   11'd0,   11'd0,
      11'd0, 11'd0},
    '{11'd1, 11'd7, 11'd21, 11'd42, 11'd35, 11'd105, 11'd140, 11'd210, 11'd0,   11'd0,
      11'd0, 11'd0},
    '{11'd1, 11'd8, 11'd28, 11'd56, 11'd56, 11'd168, 11'd70,  11'd280, 11'd420, 11'd560,
      11'd0, 11'd0},
    '{11'd1, 11'd9, 11'd36, 11'd72, 11'd84, 11'd252, 11'd126, 11'd504, 11'd756, 11'd630,
      11'd1260, 11'd1680}
  };

  // Elements per vector for each order.
  localparam logic [POS_WIDTH-1:0] VEC_LEN [NUM_ORDERS] = '{
    6'd1, 6'd3, 6'd6, 6'd10, 6'd15, 6'd21, 6'd28, 6'd36, 6'd45, 6'd55
  };

  // One classified element on its way from the front to the back.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0]  mag;
    logic [WEIGHT_WIDTH-1:0] weight;
    logic                    last;
    logic                    err;
  } work_t;

  typedef struct packed {
    logic [SUM_WIDTH-1:0] sum;
    logic                 err;
  } result_t;

  function automatic logic [WEIGHT_WIDTH-1:0] weight_of(
    input logic [ORDER_IDX_W-1:0] ord,
    input logic [POS_WIDTH-1:0]   pos
  );
    logic [WEIGHT_WIDTH-1:0] w;
    logic                    found;
    w     = '0;
    found = 1'b0;
    for (int r = 0; r < MAX_RUNS; r++) begin
      if (!found && (pos < RUN_END[ord][r])) begin
        w     = RUN_WEIGHT[ord][r];
        found = 1'b1;
      end
    end
    return w;
  endfunction

endpackage

### src/order_weighted_square_sum_core.sv
// Top level of the order-weighted sum-of-squares block.
//
// The block takes one signed Q8.16 vector element per beat, squares it, scales
// it by an integer weight chosen by the configured order and the element's
// position, and adds the product to a running total. When the last element of
// a vector arrives (1, 3, 6, 10, 15, 21, 28, 36, 45 or 55 elements for orders
// 0 through 9; order -1 acts as order 0) it delivers one result beat with the
// exact unsigned Q31.32 sum and clears the total. With any other order every
// element delivers one result beat of zero with order_error_o set. Writing the
// order register starts a new vector. Both sides behave as queues: an element
// is taken while full is low, and a result can be taken while empty is low.
// The block sustains one element per clock cycle while full stays low; that
// rate is set by the single accumulator add, which sees one product per cycle.
// On its way to a result beat an element passes the queue between the
// classifier and the arithmetic, an input register, the square, the weight
// multiply and the add. Up to six finished results wait in an output FIFO,
// and the arithmetic only starts an element that yields a result when a slot
// is reserved for that result, so the output side can stall freely.
module order_weighted_square_sum_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [owss_pkg::ORDER_WIDTH-1:0]   cfg_wdata_i,
  input  logic                               push,
  output logic                               full,
  input  logic [owss_pkg::VALUE_WIDTH-1:0]   element_value_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [owss_pkg::SUM_WIDTH-1:0]     weighted_sum_o,
  output logic                               order_error_o
);
  import owss_pkg::*;

  work_t front_item;
  work_t queue_item;
  logic  accept;
  logic  queue_empty;
  logic  queue_pop;

  assign accept = push && !full;

  // Classifies each element: order check, position, weight, end of vector.
  owss_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .accept_i        (accept),
    .element_value_i (element_value_i),
    .item_o          (front_item)
  );

  // Decouples the classifier from the arithmetic.
  owss_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (front_item),
    .full_o    (full),
    .rd_en_i   (queue_pop),
    .rd_data_o (queue_item),
    .empty_o   (queue_empty)
  );

  // Square, weight, accumulate and hold the finished results.
  owss_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clear_i        (cfg_we_i),
    .q_empty_i      (queue_empty),
    .q_item_i       (queue_item),
    .q_pop_o        (queue_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .weighted_sum_o (weighted_sum_o),
    .order_error_o  (order_error_o)
  );

endmodule

### src/owss_queue.sv
// Short FIFO of classified elements between the front and the back.
module owss_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  owss_pkg::work_t wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output owss_pkg::work_t rd_data_o,
  output logic           empty_o
);
  import owss_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  work_t           mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### src/owss_front.sv
// Front end: order register, element position and classification of each element.
module owss_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [owss_pkg::ORDER_WIDTH-1:0]   cfg_wdata_i,
  input  logic                               accept_i,
  input  logic [owss_pkg::VALUE_WIDTH-1:0]   element_value_i,
  output owss_pkg::work_t                    item_o
);
  import owss_pkg::*;

  logic signed [ORDER_WIDTH-1:0] order_q;
  logic [POS_WIDTH-1:0]          pos_q, pos_d;
  logic [ORDER_IDX_W-1:0]        ord_idx;
  logic                          ord_ok;
  logic [POS_WIDTH:0]            pos_inc;
  logic                          vec_last;

  always_comb begin
    ord_ok   = (order_q >= ORDER_WIDTH'(ORDER_MIN)) && (order_q <= ORDER_WIDTH'(ORDER_MAX));
    // Invalid orders look up order zero so the tables are never indexed past their end.
    ord_idx  = (!ord_ok || (order_q == ORDER_WIDTH'(ORDER_MIN)))
             ? '0 : order_q[ORDER_IDX_W-1:0];
    pos_inc  = {1'b0, pos_q} + 1'b1;
    vec_last = (pos_inc >= {1'b0, VEC_LEN[ord_idx]});

    // The most negative value maps to 2^(W-1), which the negation gives as-is.
    item_o.mag    = element_value_i[VALUE_WIDTH-1]
                  ? VALUE_WIDTH'(~element_value_i + 1'b1) : element_value_i;
    item_o.weight = weight_of(ord_idx, pos_q);
    item_o.last   = ord_ok && vec_last;
    item_o.err    = !ord_ok;

    pos_d = pos_q;
    if (cfg_we_i) begin
      pos_d = '0;
    end else if (accept_i) begin
      pos_d = (!ord_ok || vec_last) ? '0 : pos_inc[POS_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= '0;
      pos_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      pos_q <= pos_d;
    end
  end

endmodule

### src/owss_back.sv
// Back end: square and weight pipeline, accumulator and result FIFO.
module owss_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clear_i,
  input  logic                             q_empty_i,
  input  owss_pkg::work_t                  q_item_i,
  output logic                             q_pop_o,
  output logic                             empty_o,
  input  logic                             pop_i,
  output logic [owss_pkg::SUM_WIDTH-1:0]   weighted_sum_o,
  output logic                             order_error_o
);
  import owss_pkg::*;

  localparam int PtrW = $clog2(OUT_DEPTH);
  localparam int CntW = $clog2(OUT_DEPTH + 1);

  // Pipeline stages.
  logic                    s1_valid_q;
  work_t                   s1_item_q;
  logic                    s2_valid_q;
  logic [SQ_WIDTH-1:0]     s2_sq_q;
  logic [WEIGHT_WIDTH-1:0] s2_weight_q;
  logic                    s2_last_q, s2_err_q;
  logic                    s3_valid_q;
  logic [PROD_WIDTH-1:0]   s3_prod_q;
  logic                    s3_last_q, s3_err_q;
  logic [SUM_WIDTH-1:0]    total_q, total_d;

  // Result FIFO.
  result_t                 out_mem_q [OUT_DEPTH];
  logic [PtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]         cnt_q;
  logic                    out_push, out_pop;
  result_t                 out_data;
  logic [SUM_WIDTH-1:0]    sum_next;

  logic                    item_has_res;
  logic [CntW+1:0]         committed;
  logic                    credit_ok;

  // Results already on their way hold a FIFO slot each.
  always_comb begin
    item_has_res = q_item_i.last || q_item_i.err;
    committed    = (CntW+2)'(cnt_q)
                 + (CntW+2)'(s1_valid_q && (s1_item_q.last || s1_item_q.err))
                 + (CntW+2)'(s2_valid_q && (s2_last_q || s2_err_q))
                 + (CntW+2)'(s3_valid_q && (s3_last_q || s3_err_q));
    credit_ok    = (committed < (CntW+2)'(OUT_DEPTH));
    q_pop_o      = !q_empty_i && (!item_has_res || credit_ok);
  end

  always_comb begin
    sum_next = total_q + SUM_WIDTH'(s3_prod_q);
    out_push = s3_valid_q && (s3_last_q || s3_err_q);
    out_data.sum = s3_err_q ? '0 : sum_next;
    out_data.err = s3_err_q;
    total_d = total_q;
    if (clear_i) begin
      total_d = '0;
    end else if (s3_valid_q) begin
      total_d = (s3_last_q || s3_err_q) ? '0 : sum_next;
    end
  end

  assign empty_o        = (cnt_q == '0);
  assign out_pop        = pop_i && !empty_o;
  assign weighted_sum_o = out_mem_q[rd_ptr_q].sum;
  assign order_error_o  = out_mem_q[rd_ptr_q].err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      total_q    <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= q_pop_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      total_q    <= total_d;
      if (out_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (out_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (out_push && !out_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (out_pop && !out_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q   <= q_item_i;
    s2_sq_q     <= SQ_WIDTH'(s1_item_q.mag) * SQ_WIDTH'(s1_item_q.mag);
    s2_weight_q <= s1_item_q.weight;
    s2_last_q   <= s1_item_q.last;
    s2_err_q    <= s1_item_q.err;
    s3_prod_q   <= PROD_WIDTH'(s2_sq_q) * PROD_WIDTH'(s2_weight_q);
    s3_last_q   <= s2_last_q;
    s3_err_q    <= s2_err_q;
    if (out_push) begin
      out_mem_q[wr_ptr_q] <= out_data;
    end
  end

endmodule
